// ===== rtl/bcdc_pkg.sv =====
// shared types and constants for the battery compensated duty cycle block
// no dependencies; used by bcdc_div and the top level

package bcdc_pkg;

  // serial divider geometry
  localparam int NUM_W  = 26;
  localparam int DEN_W  = 12;
  localparam int CNT_W  = 5;
  localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(NUM_W);

  // value limits
  localparam logic [11:0] BATT_MAX  = 12'd3200;
  localparam logic [13:0] CMD_MAX   = 14'd10000;
  localparam logic [25:0] COMP_GAIN = 26'd1000;
  localparam logic [25:0] ROUND_OFS = 26'd500;
  localparam logic [11:0] MAP_DEN   = 12'd1000;
  localparam logic [11:0] PWM_DEN   = 12'd625;

  // configuration register indexes
  localparam logic [2:0] REG_NOMINAL  = 3'd0;
  localparam logic [2:0] REG_SAT_LOW  = 3'd1;
  localparam logic [2:0] REG_SAT_HIGH = 3'd2;
  localparam logic [2:0] REG_DUTY_ZER = 3'd3;
  localparam logic [2:0] REG_DUTY_FUL = 3'd4;
  localparam logic [2:0] REG_INVERT   = 3'd5;

  // request into the shared divider
  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] numer;
    logic [DEN_W-1:0] denom;
  } div_req_t;

endpackage

// ===== rtl/bcdc_div.sv =====
// bit-serial restoring divider, one quotient bit per cycle
// depends on bcdc_pkg for widths and the request struct

module bcdc_div (
  input  logic                   clk,
  input  logic                   rst,
  input  bcdc_pkg::div_req_t     req,
  output logic                   done,
  output logic [bcdc_pkg::NUM_W-1:0] quot
);
  import bcdc_pkg::*;

  logic [CNT_W-1:0] cnt;
  logic [NUM_W-1:0] acc;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [DEN_W:0]   trial;
  logic             fits;

  // numerator shifts out at the top, quotient bits shift in at the bottom
  assign trial = {rem, acc[NUM_W-1]};
  assign fits  = (trial >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        cnt <= DIV_STEPS;
      end else if (cnt != '0) begin
        cnt  <= cnt - CNT_W'(1);
        done <= (cnt == CNT_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc <= req.numer;
      rem <= '0;
      den <= req.denom;
    end else if (cnt != '0) begin
      acc <= {acc[NUM_W-2:0], fits};
      rem <= fits ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
    end
  end

  assign quot = acc;

endmodule

// ===== rtl/battery_compensated_duty_cycle.sv =====
// Battery compensated duty cycle: filters the battery sample, compensates the
// request for battery voltage and maps it onto a PWM duty value. Uses bcdc_pkg
// and bcdc_div. One transaction is worked on at a time. Its three divisions
// (compensation, duty mapping with rounding, PWM scaling) run one after the
// other on the shared bit-serial divider, and the next input is taken the
// cycle after the result is placed in the output register. A finished result
// waits there without holding up the next input. The first sample after reset
// serves as its own predecessor in the two-sample average.

module battery_compensated_duty_cycle (
  input  logic        clk,
  input  logic        rst,
  // apb configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // battery_sample[15:0], power_request, test_setpoint
  input  logic        s_axis_tuser,  // test_active
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [87:0] m_axis_tdata   // filtered_battery[11:0], corrected_command,
                                     // saturated_command, converted_duty,
                                     // drive_duty, pwm_register, zero pad
);
  import bcdc_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV1 = 3'd1;
  localparam logic [2:0] ST_MAP  = 3'd2;
  localparam logic [2:0] ST_DIV2 = 3'd3;
  localparam logic [2:0] ST_DIV3 = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  // configuration
  logic [7:0] nominal_battery;
  logic [9:0] sat_low;
  logic [9:0] sat_high;
  logic [9:0] duty_at_zero;
  logic [9:0] duty_at_full;
  logic       invert_duty;
  logic       cfg_wr;

  logic [2:0]  state;
  logic        s_accept;
  logic        m_load;

  // state and working registers
  logic [11:0] previous_battery;
  logic        primed;
  logic [11:0] filt;
  logic [13:0] cor;
  logic [13:0] sat;
  logic [13:0] cnv;
  logic [13:0] drv;
  logic [15:0] pwm;

  // divider
  div_req_t         div_req;
  logic             div_done;
  logic [NUM_W-1:0] div_quot;

  // ---------------------------------------------------------------- apb
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      nominal_battery <= 8'd0;
      sat_low         <= 10'd0;
      sat_high        <= 10'd1000;
      duty_at_zero    <= 10'd0;
      duty_at_full    <= 10'd1000;
      invert_duty     <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_NOMINAL:  nominal_battery <= pwdata[7:0];
        REG_SAT_LOW:  sat_low         <= pwdata[9:0];
        REG_SAT_HIGH: sat_high        <= pwdata[9:0];
        REG_DUTY_ZER: duty_at_zero    <= pwdata[9:0];
        REG_DUTY_FUL: duty_at_full    <= pwdata[9:0];
        REG_INVERT:   invert_duty     <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_NOMINAL:  prdata = {24'd0, nominal_battery};
      REG_SAT_LOW:  prdata = {22'd0, sat_low};
      REG_SAT_HIGH: prdata = {22'd0, sat_high};
      REG_DUTY_ZER: prdata = {22'd0, duty_at_zero};
      REG_DUTY_FUL: prdata = {22'd0, duty_at_full};
      REG_INVERT:   prdata = {31'd0, invert_duty};
      default:      prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------- filter
  logic signed [15:0] samp;
  logic [11:0]        samp_clamp;
  logic [11:0]        prev_eff;
  logic signed [17:0] avg_sum;
  logic [15:0]        avg_half;
  logic [11:0]        filt_c;
  logic [7:0]         req_sel;
  logic [15:0]        req_prod;
  logic [NUM_W-1:0]   numer1;

  assign samp       = s_axis_tdata[15:0];
  assign samp_clamp = samp[15] ? 12'd0 :
                      (samp > $signed({4'd0, BATT_MAX})) ? BATT_MAX : samp[11:0];
  assign prev_eff   = primed ? previous_battery : samp_clamp;
  assign avg_sum    = {{2{samp[15]}}, samp} + $signed({6'd0, prev_eff});
  // a negative sum halves to zero or below, which clamps to zero either way
  assign avg_half   = avg_sum[16:1];
  assign filt_c     = avg_sum[17] ? 12'd0 :
                      (avg_half > {4'd0, BATT_MAX}) ? BATT_MAX : avg_half[11:0];

  assign req_sel  = s_axis_tuser ? s_axis_tdata[31:24] : s_axis_tdata[23:16];
  assign req_prod = nominal_battery * req_sel;
  assign numer1   = {10'd0, req_prod} * COMP_GAIN;

  // ---------------------------------------------------------------- compensation cap
  logic [13:0] cor_c;
  assign cor_c = (filt == 12'd0) ? 14'd0 :
                 (div_quot > {12'd0, CMD_MAX}) ? CMD_MAX : div_quot[13:0];

  // ---------------------------------------------------------------- saturation
  logic [13:0] lo_bound;
  logic [13:0] hi_bound;
  logic [13:0] sat_a;
  logic [13:0] sat_b;
  logic [13:0] sat_c;
  logic        rising;
  logic [9:0]  delta;
  logic [23:0] map_prod;
  logic [NUM_W-1:0] numer2;

  assign lo_bound = {1'b0, sat_low, 3'd0} + {3'd0, sat_low, 1'b0};
  assign hi_bound = {1'b0, sat_high, 3'd0} + {3'd0, sat_high, 1'b0};
  assign sat_a    = (cor > hi_bound) ? hi_bound : cor;
  assign sat_b    = (sat_a < lo_bound) ? lo_bound : sat_a;
  assign sat_c    = (sat_b > CMD_MAX) ? CMD_MAX : sat_b;

  assign rising   = (duty_at_full > duty_at_zero);
  assign delta    = rising ? (duty_at_full - duty_at_zero) : (duty_at_zero - duty_at_full);
  assign map_prod = sat_c * delta;
  assign numer2   = {2'd0, map_prod} + ROUND_OFS;

  // ---------------------------------------------------------------- duty mapping
  logic [13:0] zero10;
  logic [13:0] rnd;
  logic [14:0] up_sum;
  logic [13:0] down_diff;
  logic [13:0] cnv_c;
  logic [13:0] drv_c;
  logic [NUM_W-1:0] numer3;

  assign zero10    = {1'b0, duty_at_zero, 3'd0} + {3'd0, duty_at_zero, 1'b0};
  assign rnd       = div_quot[13:0];
  assign up_sum    = {1'b0, zero10} + {1'b0, rnd};
  assign down_diff = (rnd > zero10) ? 14'd0 : (zero10 - rnd);
  always_comb begin
    if (rising) begin
      cnv_c = (up_sum > {1'b0, CMD_MAX}) ? CMD_MAX : up_sum[13:0];
    end else begin
      cnv_c = (down_diff > CMD_MAX) ? CMD_MAX : down_diff;
    end
  end
  assign drv_c  = invert_duty ? (CMD_MAX - cnv_c) : cnv_c;
  assign numer3 = {1'b0, drv_c, 11'd0};

  // ---------------------------------------------------------------- sequencer
  assign s_axis_tready = (state == ST_IDLE);
  assign s_accept      = s_axis_tvalid & s_axis_tready;
  assign m_load        = (state == ST_FIN) & (~m_axis_tvalid | m_axis_tready);

  always_comb begin
    div_req.start = 1'b0;
    div_req.numer = numer1;
    div_req.denom = filt_c;
    unique case (state)
      ST_IDLE: div_req.start = s_accept;
      ST_MAP: begin
        div_req.start = 1'b1;
        div_req.numer = numer2;
        div_req.denom = MAP_DEN;
      end
      ST_DIV2: begin
        div_req.start = div_done;
        div_req.numer = numer3;
        div_req.denom = PWM_DEN;
      end
      default: ;
    endcase
  end

  bcdc_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .done (div_done),
    .quot (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      primed           <= 1'b0;
      previous_battery <= 12'd0;
      m_axis_tvalid    <= 1'b0;
    end else begin
      if (m_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (s_accept) begin
        primed           <= 1'b1;
        previous_battery <= samp_clamp;
      end
      unique case (state)
        ST_IDLE: if (s_accept) state <= ST_DIV1;
        ST_DIV1: if (div_done) state <= ST_MAP;
        ST_MAP:  state <= ST_DIV2;
        ST_DIV2: if (div_done) state <= ST_DIV3;
        ST_DIV3: if (div_done) state <= ST_FIN;
        ST_FIN:  if (m_load) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) filt <= filt_c;
    if (state == ST_DIV1 && div_done) cor <= cor_c;
    if (state == ST_MAP) sat <= sat_c;
    if (state == ST_DIV2 && div_done) begin
      cnv <= cnv_c;
      drv <= drv_c;
    end
    if (state == ST_DIV3 && div_done) pwm <= div_quot[15:0];
    if (m_load) m_axis_tdata <= {4'd0, pwm, drv, cnv, sat, cor, filt};
  end

  // ---------------------------------------------------------------- checks
  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV1 || state == ST_DIV2 || state == ST_DIV3))
    else $error("divider finished outside a division step");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    s_accept |=> (state == ST_DIV1))
    else $error("accepted transaction did not start compensation");

  a_result_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[11:0] <= BATT_MAX && m_axis_tdata[25:12] <= CMD_MAX
                       && m_axis_tdata[39:26] <= CMD_MAX))
    else $error("result field out of range");

  a_zero_battery: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[11:0] == 12'd0) |-> (m_axis_tdata[25:12] == 14'd0))
    else $error("nonzero command with zero battery voltage");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("pending result overwritten");

endmodule
